### rtl/core/pis_pkg.sv
// shared constants, types and codes for the point-in-shape tester
`timescale 1ns / 1ps

package pis_pkg;

    // sizing
    localparam int MAX_VERTICES = 64;
    localparam int COORD_WIDTH  = 16;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int DIFF_W       = COORD_WIDTH + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int REG_IDX_W    = 3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [PROD_W:0]        sum_t;
    typedef logic [CNT_W-1:0]              cnt_t;
    typedef logic [IDX_W-1:0]              idx_t;

    // command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // shape kinds
    localparam logic [1:0] SHAPE_BOX     = 2'd0;
    localparam logic [1:0] SHAPE_CIRCLE  = 2'd1;
    localparam logic [1:0] SHAPE_POLYGON = 2'd2;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_SHAPE_KIND = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_X  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Y  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_X  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Y  = 3'd4;

    // control of one vertex cell
    typedef struct packed {
        logic write;
        logic shift;
        logic wrap;
    } cell_ctl_t;

    // control into the edge unit
    typedef struct packed {
        logic clr;
        logic valid;
    } edge_ctl_t;

    // status out of the edge unit
    typedef struct packed {
        logic parity;
        logic idle;
    } edge_stat_t;

endpackage

### rtl/core/pis_cell.sv
// one vertex cell of the rotating vertex ring
`timescale 1ns / 1ps

module pis_cell (
    input  logic               clk,
    input  pis_pkg::cell_ctl_t ctl,
    input  pis_pkg::coord_t    wr_x,
    input  pis_pkg::coord_t    wr_y,
    input  pis_pkg::coord_t    next_x,
    input  pis_pkg::coord_t    next_y,
    input  pis_pkg::coord_t    head_x,
    input  pis_pkg::coord_t    head_y,
    output pis_pkg::coord_t    x,
    output pis_pkg::coord_t    y
);

    pis_pkg::coord_t x_reg, x_next;
    pis_pkg::coord_t y_reg, y_next;

    // append load, or take from the neighbour (head when closing the ring)
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        if (ctl.write)
        begin
            x_next = wr_x;
            y_next = wr_y;
        end
        else if (ctl.shift)
        begin
            x_next = ctl.wrap ? head_x : next_x;
            y_next = ctl.wrap ? head_y : next_y;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign x = x_reg;
    assign y = y_reg;

endmodule

### rtl/core/pis_edge_unit.sv
// shared crossing test for one polygon edge per cycle, three stages deep
`timescale 1ns / 1ps

module pis_edge_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  pis_pkg::edge_ctl_t  ctl,
    input  pis_pkg::coord_t     a_x,
    input  pis_pkg::coord_t     a_y,
    input  pis_pkg::coord_t     b_x,
    input  pis_pkg::coord_t     b_y,
    input  pis_pkg::coord_t     p_x,
    input  pis_pkg::coord_t     p_y,
    output pis_pkg::edge_stat_t stat
);

    logic           v1_reg, v1_next;
    logic           v2_reg, v2_next;
    logic           parity_reg, parity_next;
    logic           cond1_reg, cond1_next;
    logic           dneg1_reg, dneg1_next;
    logic           cond2_reg, cond2_next;
    logic           dneg2_reg, dneg2_next;
    pis_pkg::diff_t dx_reg, dx_next;
    pis_pkg::diff_t d_reg, d_next;
    pis_pkg::diff_t ex_reg, ex_next;
    pis_pkg::diff_t ey_reg, ey_next;
    pis_pkg::prod_t p1_reg, p1_next;
    pis_pkg::prod_t p2_reg, p2_next;
    logic           flip;

    // stage 1: straddle check and coordinate differences
    always_comb
    begin
        v1_next    = ctl.valid;
        cond1_next = (a_y > p_y) != (b_y > p_y);
        d_next     = pis_pkg::diff_t'(b_y) - pis_pkg::diff_t'(a_y);
        dneg1_next = b_y < a_y;
        dx_next    = pis_pkg::diff_t'(p_x) - pis_pkg::diff_t'(a_x);
        ex_next    = pis_pkg::diff_t'(b_x) - pis_pkg::diff_t'(a_x);
        ey_next    = pis_pkg::diff_t'(p_y) - pis_pkg::diff_t'(a_y);
    end

    // stage 2: the two cross products
    always_comb
    begin
        v2_next    = v1_reg;
        cond2_next = cond1_reg;
        dneg2_next = dneg1_reg;
        p1_next    = pis_pkg::prod_t'(dx_reg) * pis_pkg::prod_t'(d_reg);
        p2_next    = pis_pkg::prod_t'(ex_reg) * pis_pkg::prod_t'(ey_reg);
    end

    // stage 3: point left of the crossing toggles the parity
    assign flip = v2_reg && cond2_reg && (dneg2_reg ? (p1_reg > p2_reg) : (p1_reg < p2_reg));

    always_comb
    begin
        parity_next = parity_reg;
        if (ctl.clr)
        begin
            parity_next = 1'b0;
        end
        else if (flip)
        begin
            parity_next = !parity_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            parity_reg <= 1'b0;
        end
        else
        begin
            v1_reg     <= v1_next;
            v2_reg     <= v2_next;
            parity_reg <= parity_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cond1_reg <= cond1_next;
        dneg1_reg <= dneg1_next;
        dx_reg    <= dx_next;
        d_reg     <= d_next;
        ex_reg    <= ex_next;
        ey_reg    <= ey_next;
        cond2_reg <= cond2_next;
        dneg2_reg <= dneg2_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
    end

    assign stat.parity = parity_reg;
    assign stat.idle   = !v1_reg && !v2_reg;

endmodule

### rtl/core/pis_circle_unit.sv
// squared distance against squared radius, three stages deep
`timescale 1ns / 1ps

module pis_circle_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            go,
    input  pis_pkg::coord_t p_x,
    input  pis_pkg::coord_t p_y,
    input  pis_pkg::coord_t c_x,
    input  pis_pkg::coord_t c_y,
    input  pis_pkg::coord_t rad,
    output logic            done,
    output logic            hit
);

    logic           v1_reg, v2_reg, done_reg;
    logic           inside_reg, inside_next;
    pis_pkg::diff_t dx_reg, dx_next;
    pis_pkg::diff_t dy_reg, dy_next;
    pis_pkg::diff_t r_reg, r_next;
    pis_pkg::prod_t sqx_reg, sqx_next;
    pis_pkg::prod_t sqy_reg, sqy_next;
    pis_pkg::prod_t sqr_reg, sqr_next;

    // offsets from the centre
    always_comb
    begin
        dx_next = pis_pkg::diff_t'(p_x) - pis_pkg::diff_t'(c_x);
        dy_next = pis_pkg::diff_t'(p_y) - pis_pkg::diff_t'(c_y);
        r_next  = pis_pkg::diff_t'(rad);
    end

    // squares, one multiplier each
    always_comb
    begin
        sqx_next = pis_pkg::prod_t'(dx_reg) * pis_pkg::prod_t'(dx_reg);
        sqy_next = pis_pkg::prod_t'(dy_reg) * pis_pkg::prod_t'(dy_reg);
        sqr_next = pis_pkg::prod_t'(r_reg) * pis_pkg::prod_t'(r_reg);
    end

    // boundary counts as inside
    assign inside_next = (pis_pkg::sum_t'(sqx_reg) + pis_pkg::sum_t'(sqy_reg))
                         <= pis_pkg::sum_t'(sqr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= go;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        r_reg      <= r_next;
        sqx_reg    <= sqx_next;
        sqy_reg    <= sqy_next;
        sqr_reg    <= sqr_next;
        inside_reg <= inside_next;
    end

    assign done = done_reg;
    assign hit  = inside_reg;

endmodule

### rtl/core/point_in_shape_test.sv
// top level: command decode, vertex ring, shape tests and result register
`timescale 1ns / 1ps

// channel   | signals                        | transfer at rising edge
// ----------+--------------------------------+--------------------------
// command   | start busy command coord_x/y   | start && !busy
// result    | done inside_res overflowed     | done (one cycle, no stall)
// config    | cfg_we cfg_idx cfg_data        | cfg_we
//
// clear and append leave busy low; the next command may follow. a box query
// strobes done in the next cycle; a circle query once the circle unit answers.
// a polygon query of n vertices rotates the vertex ring once, one edge per cycle
// through the shared edge unit, lets the edge unit drain and then strobes done;
// busy stays high through the walk and the drain. an empty polygon answers in the
// next cycle. reset clears the count, the overflow flag and the state, result and
// config registers, not the vertex cells. the receiver cannot hold a result off.

module point_in_shape_test (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        command,
    input  logic signed [pis_pkg::COORD_WIDTH-1:0] coord_x,
    input  logic signed [pis_pkg::COORD_WIDTH-1:0] coord_y,
    output logic                              done,
    output logic                              inside_res,
    output logic                              overflowed,
    input  logic                              cfg_we,
    input  logic [pis_pkg::REG_IDX_W-1:0]     cfg_idx,
    input  logic [pis_pkg::COORD_WIDTH-1:0]   cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CIRC,
        ST_POLY,
        ST_DRAIN
    } state_t;

    state_t          state_reg, state_next;
    pis_pkg::cnt_t   count_reg, count_next;
    pis_pkg::cnt_t   count_m1;
    pis_pkg::idx_t   step_reg, step_next;
    logic            ovf_reg, ovf_next;
    logic            done_reg, done_next;
    logic            inside_reg, inside_next;
    logic            ovf_out_reg, ovf_out_next;

    logic [1:0]      shape_kind_reg;
    pis_pkg::coord_t box_min_x_reg, box_min_y_reg, box_max_x_reg, box_max_y_reg;

    pis_pkg::coord_t px_reg, py_reg, px_next, py_next;
    pis_pkg::coord_t last_x_reg, last_y_reg, last_x_next, last_y_next;
    pis_pkg::coord_t prev_x_reg, prev_y_reg, prev_x_next, prev_y_next;

    logic            accept;
    logic            is_query;
    logic            box_hit;
    logic            room;
    logic            circ_go;
    logic            circ_done;
    logic            circ_inside;

    pis_pkg::edge_ctl_t  edge_ctl;
    pis_pkg::edge_stat_t edge_stat;

    pis_pkg::coord_t cell_x [pis_pkg::MAX_VERTICES];
    pis_pkg::coord_t cell_y [pis_pkg::MAX_VERTICES];

    assign accept   = start && !busy;
    assign is_query = accept && (command == pis_pkg::CMD_QUERY);
    assign room     = count_reg < pis_pkg::cnt_t'(pis_pkg::MAX_VERTICES);
    assign count_m1 = count_reg - pis_pkg::cnt_t'(1);

    // inclusive bounds on both axes
    assign box_hit = (coord_x >= box_min_x_reg) && (coord_x <= box_max_x_reg) &&
                     (coord_y >= box_min_y_reg) && (coord_y <= box_max_y_reg);

    assign circ_go       = is_query && (shape_kind_reg == pis_pkg::SHAPE_CIRCLE);
    assign edge_ctl.clr   = is_query && (shape_kind_reg == pis_pkg::SHAPE_POLYGON);
    assign edge_ctl.valid = (state_reg == ST_POLY);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_kind_reg <= pis_pkg::SHAPE_BOX;
            box_min_x_reg  <= '0;
            box_min_y_reg  <= '0;
            box_max_x_reg  <= '0;
            box_max_y_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                pis_pkg::REG_SHAPE_KIND: shape_kind_reg <= cfg_data[1:0];
                pis_pkg::REG_BOX_MIN_X:  box_min_x_reg  <= cfg_data;
                pis_pkg::REG_BOX_MIN_Y:  box_min_y_reg  <= cfg_data;
                pis_pkg::REG_BOX_MAX_X:  box_max_x_reg  <= cfg_data;
                pis_pkg::REG_BOX_MAX_Y:  box_max_y_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // vertex ring: cell k takes from k+1, the last live cell from the head
    genvar k;
    generate
        for (k = 0; k < pis_pkg::MAX_VERTICES; k++)
        begin : g_cell
            pis_pkg::cell_ctl_t cctl;
            pis_pkg::coord_t    nx, ny;

            assign cctl.write = accept && (command == pis_pkg::CMD_APPEND) && room &&
                                (count_reg[pis_pkg::IDX_W-1:0] == pis_pkg::idx_t'(k));
            assign cctl.shift = (state_reg == ST_POLY) && (pis_pkg::cnt_t'(k) < count_reg);
            assign cctl.wrap  = (pis_pkg::cnt_t'(k) == count_m1);

            if (k == pis_pkg::MAX_VERTICES - 1)
            begin : g_tail
                assign nx = cell_x[0];
                assign ny = cell_y[0];
            end
            else
            begin : g_mid
                assign nx = cell_x[k+1];
                assign ny = cell_y[k+1];
            end

            pis_cell u_cell (
                .clk    (clk),
                .ctl    (cctl),
                .wr_x   (coord_x),
                .wr_y   (coord_y),
                .next_x (nx),
                .next_y (ny),
                .head_x (cell_x[0]),
                .head_y (cell_y[0]),
                .x      (cell_x[k]),
                .y      (cell_y[k])
            );
        end
    endgenerate

    // shared edge test fed from the head of the ring
    pis_edge_unit u_edge (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (edge_ctl),
        .a_x   (cell_x[0]),
        .a_y   (cell_y[0]),
        .b_x   (prev_x_reg),
        .b_y   (prev_y_reg),
        .p_x   (px_reg),
        .p_y   (py_reg),
        .stat  (edge_stat)
    );

    pis_circle_unit u_circle (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (circ_go),
        .p_x    (coord_x),
        .p_y    (coord_y),
        .c_x    (box_min_x_reg),
        .c_y    (box_min_y_reg),
        .rad    (box_max_x_reg),
        .done   (circ_done),
        .hit    (circ_inside)
    );

    // command sequencing
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        step_next    = step_reg;
        done_next    = 1'b0;
        inside_next  = inside_reg;
        ovf_out_next = ovf_out_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        pis_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                        pis_pkg::CMD_APPEND:
                        begin
                            if (room)
                            begin
                                count_next = count_reg + pis_pkg::cnt_t'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        pis_pkg::CMD_QUERY:
                        begin
                            unique case (shape_kind_reg)
                                pis_pkg::SHAPE_CIRCLE:
                                begin
                                    state_next = ST_CIRC;
                                end
                                pis_pkg::SHAPE_POLYGON:
                                begin
                                    if (count_reg == '0)
                                    begin
                                        done_next    = 1'b1;
                                        inside_next  = 1'b0;
                                        ovf_out_next = ovf_reg;
                                    end
                                    else
                                    begin
                                        state_next = ST_POLY;
                                        step_next  = '0;
                                    end
                                end
                                default:
                                begin
                                    done_next    = 1'b1;
                                    inside_next  = box_hit;
                                    ovf_out_next = ovf_reg;
                                end
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            ST_CIRC:
            begin
                if (circ_done)
                begin
                    done_next    = 1'b1;
                    inside_next  = circ_inside;
                    ovf_out_next = ovf_reg;
                    state_next   = ST_IDLE;
                end
            end
            ST_POLY:
            begin
                step_next = step_reg + pis_pkg::idx_t'(1);
                if (pis_pkg::cnt_t'(step_reg) == count_m1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (edge_stat.idle)
                begin
                    done_next    = 1'b1;
                    inside_next  = edge_stat.parity;
                    ovf_out_next = ovf_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            step_reg    <= '0;
            done_reg    <= 1'b0;
            inside_reg  <= 1'b0;
            ovf_out_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            step_reg    <= step_next;
            done_reg    <= done_next;
            inside_reg  <= inside_next;
            ovf_out_reg <= ovf_out_next;
        end
    end

    // query point, last appended vertex and trailing edge end
    always_comb
    begin
        px_next     = px_reg;
        py_next     = py_reg;
        last_x_next = last_x_reg;
        last_y_next = last_y_reg;
        prev_x_next = prev_x_reg;
        prev_y_next = prev_y_reg;
        if (is_query)
        begin
            px_next     = coord_x;
            py_next     = coord_y;
            prev_x_next = last_x_reg;
            prev_y_next = last_y_reg;
        end
        if (accept && (command == pis_pkg::CMD_APPEND) && room)
        begin
            last_x_next = coord_x;
            last_y_next = coord_y;
        end
        if (state_reg == ST_POLY)
        begin
            prev_x_next = cell_x[0];
            prev_y_next = cell_y[0];
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        last_x_reg <= last_x_next;
        last_y_reg <= last_y_next;
        prev_x_reg <= prev_x_next;
        prev_y_reg <= prev_y_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign inside_res = inside_reg;
    assign overflowed = ovf_out_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pis_pkg::cnt_t'(pis_pkg::MAX_VERTICES))
        else $error("vertex count beyond capacity");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POLY) |-> (pis_pkg::cnt_t'(step_reg) < count_reg))
        else $error("ring walk beyond vertex count");

    a_full_sets_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (command == pis_pkg::CMD_APPEND) && !room) |=> ovf_reg)
        else $error("dropped append did not set overflow");

    a_poly_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (is_query && (shape_kind_reg == pis_pkg::SHAPE_POLYGON) && (count_reg != '0))
        |=> (busy && !done))
        else $error("polygon query did not start the ring walk");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == ST_IDLE))
        else $error("result strobe while still walking");

endmodule
